### src/aff_pkg.sv
// Shared types and constants for the affine 3x4 matrix inverse unit.
package aff_pkg;

  localparam int unsigned DEF_FRAC_BITS = 16;
  localparam int unsigned DEF_WORD_BITS = 32;
  localparam int unsigned ELEM_W        = 32;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // One input matrix: rows of three linear entries plus translation
  typedef struct packed {
    logic signed [ELEM_W-1:0] r0c0;
    logic signed [ELEM_W-1:0] r0c1;
    logic signed [ELEM_W-1:0] r0c2;
    logic signed [ELEM_W-1:0] r0c3;
    logic signed [ELEM_W-1:0] r1c0;
    logic signed [ELEM_W-1:0] r1c1;
    logic signed [ELEM_W-1:0] r1c2;
    logic signed [ELEM_W-1:0] r1c3;
    logic signed [ELEM_W-1:0] r2c0;
    logic signed [ELEM_W-1:0] r2c1;
    logic signed [ELEM_W-1:0] r2c2;
    logic signed [ELEM_W-1:0] r2c3;
  } in_item_t;

  // One element of the inverse
  typedef struct packed {
    logic [IDX_W-1:0]         element_index;
    logic signed [ELEM_W-1:0] element_value;
    logic                     singular;
    logic                     last_element;
  } out_item_t;

endpackage

### src/aff_fifo.sv
// Small register queue used on both sides of the inverse engine.
module aff_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  T     data_i,
  input  logic push_i,
  output logic full_o,
  output T     data_o,
  input  logic pop_i,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/aff_back.sv
// Inverse engine: sequenced cofactor/determinant products, then per-element division.
module aff_back #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aff_pkg::in_item_t mat_i,
  input  logic              mat_valid_i,
  output logic              mat_pop_o,
  output aff_pkg::out_item_t res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);
  import aff_pkg::*;

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned OPW   = W + 1;
  localparam int unsigned PW    = 2 * W + 2;
  localparam int unsigned CW    = 2 * W + 1;
  localparam int unsigned AW    = 3 * W + 4;
  localparam int unsigned DW    = 4 * W + 2 * FRAC_BITS + 6;
  localparam int unsigned QW    = W + 1;
  localparam int unsigned MW    = W + 2;
  localparam int unsigned BIT_W = $clog2(W + 2);
  localparam logic [5:0]  NOPS  = 6'd42;

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_INIT, S_RUN, S_OUT} state_e;
  typedef enum logic [1:0] {A_ENT, A_CLO, A_CHI} asrc_e;
  typedef enum logic [1:0] {D_NONE, D_COF, D_DET, D_TR} dst_e;

  typedef struct packed {
    asrc_e      asrc;
    logic [3:0] aidx;
    logic [3:0] bidx;
    logic       hi;
    logic       neg;
    logic       first;
    dst_e       dst;
    logic [3:0] didx;
  } op_t;

  typedef struct packed {
    logic       hi;
    logic       neg;
    logic       first;
    dst_e       dst;
    logic [3:0] didx;
  } tag_t;

  // sign-extend an input entry from its low WORD_BITS bits
  function automatic logic signed [OPW-1:0] ext(logic [ELEM_W-1:0] x);
    return {x[W-1], x[W-1:0]};
  endfunction

  // product schedule: 9 cofactors, determinant, 3 translation numerators
  function automatic op_t op_at(logic [5:0] s);
    op_t        o;
    logic [3:0] i, j;
    logic [4:0] u, t;
    logic [1:0] r, tc;
    o = '0;
    i = '0;
    j = '0;
    u = '0;
    t = '0;
    r = '0;
    tc = '0;
    if (s < 6'd18) begin
      case (s[4:1])
        4'd0:    begin i = s[0] ? 4'd9 : 4'd5;  j = s[0] ? 4'd6  : 4'd10; end
        4'd1:    begin i = s[0] ? 4'd1 : 4'd9;  j = s[0] ? 4'd10 : 4'd2;  end
        4'd2:    begin i = s[0] ? 4'd5 : 4'd1;  j = s[0] ? 4'd2  : 4'd6;  end
        4'd3:    begin i = s[0] ? 4'd4 : 4'd8;  j = s[0] ? 4'd10 : 4'd6;  end
        4'd4:    begin i = s[0] ? 4'd8 : 4'd0;  j = s[0] ? 4'd2  : 4'd10; end
        4'd5:    begin i = s[0] ? 4'd0 : 4'd4;  j = s[0] ? 4'd6  : 4'd2;  end
        4'd6:    begin i = s[0] ? 4'd8 : 4'd4;  j = s[0] ? 4'd5  : 4'd9;  end
        4'd7:    begin i = s[0] ? 4'd0 : 4'd8;  j = s[0] ? 4'd9  : 4'd1;  end
        4'd8:    begin i = s[0] ? 4'd4 : 4'd0;  j = s[0] ? 4'd1  : 4'd5;  end
        default: begin i = '0; j = '0; end
      endcase
      o.asrc  = A_ENT;
      o.aidx  = i;
      o.bidx  = j;
      o.neg   = s[0];
      o.first = !s[0];
      o.dst   = s[0] ? D_COF : D_NONE;
      o.didx  = s[4:1];
    end else if (s < 6'd24) begin
      // det = m0*cof0 + m1*cof3 + m2*cof6, cofactor split into low and high halves
      t       = 5'(s - 6'd18);
      tc      = t[2:1];
      o.asrc  = t[0] ? A_CHI : A_CLO;
      o.aidx  = 4'({tc, 1'b0}) + 4'(tc);
      o.bidx  = 4'(tc);
      o.hi    = t[0];
      o.first = (t == 5'd0);
      o.dst   = (t == 5'd5) ? D_DET : D_NONE;
    end else begin
      // tr[r] = -(cof[3r]*m3 + cof[3r+1]*m7 + cof[3r+2]*m11)
      u       = 5'(s - 6'd24);
      r       = (u < 5'd6) ? 2'd0 : ((u < 5'd12) ? 2'd1 : 2'd2);
      t       = u - ((r == 2'd0) ? 5'd0 : ((r == 2'd1) ? 5'd6 : 5'd12));
      tc      = t[2:1];
      o.asrc  = t[0] ? A_CHI : A_CLO;
      o.aidx  = 4'({r, 1'b0}) + 4'(r) + 4'(tc);
      o.bidx  = 4'({tc, 2'b11});
      o.hi    = t[0];
      o.neg   = 1'b1;
      o.first = (t == 5'd0);
      o.dst   = (t == 5'd5) ? D_TR : D_NONE;
      o.didx  = 4'(r);
    end
    return o;
  endfunction

  state_e             state_q;
  logic [5:0]         step_q;
  logic [BIT_W-1:0]   bit_q;
  logic [1:0]         row_q, col_q;
  logic               mvld_q;
  tag_t               tag_q;

  logic signed [OPW-1:0] m_q   [12];
  logic signed [CW-1:0]  cof_q [9];
  logic signed [AW-1:0]  tr_q  [3];
  logic signed [AW-1:0]  det_q, acc_q, acc_d, term, base;
  logic signed [PW-1:0]  prod_q;
  logic signed [OPW-1:0] a_op, b_op;
  logic [DW-1:0]         r_q, d_q;
  logic [AW-1:0]         dabs_q;
  logic [QW-1:0]         q_q;
  logic                  ovf_q, neg_q, sing_q;

  op_t                  op;
  logic                 issue;
  logic signed [AW-1:0] num;
  logic [AW-1:0]        nmag, dmag;
  logic [DW-1:0]        nsh;
  logic                 ge, rnd, last, sing_now, push_ok;
  logic [MW-1:0]        mag, cap, magc;
  logic [W-1:0]         val_w;
  logic [3:0]           cidx;

  assign op        = op_at(step_q);
  assign issue     = (state_q == S_CALC) && (step_q < NOPS);
  assign mat_pop_o = (state_q == S_IDLE) && mat_valid_i;
  assign last      = (row_q == 2'd2) && (col_q == 2'd3);
  assign push_ok   = (state_q == S_OUT) && !res_full_i;
  assign res_push_o = push_ok;

  // multiplier operand selection
  always_comb begin
    case (op.asrc)
      A_ENT:   a_op = m_q[op.aidx];
      A_CLO:   a_op = signed'({1'b0, cof_q[op.aidx][W-1:0]});
      A_CHI:   a_op = cof_q[op.aidx][CW-1:W];
      default: a_op = m_q[op.aidx];
    endcase
    b_op = m_q[op.bidx];
  end

  // accumulate stage
  always_comb begin
    term  = AW'(prod_q);
    if (tag_q.hi) begin
      term = term <<< W;
    end
    base  = tag_q.first ? '0 : acc_q;
    acc_d = tag_q.neg ? base - term : base + term;
  end

  // division setup: numerator and divisor magnitudes
  always_comb begin
    cidx     = 4'({row_q, 1'b0}) + 4'(row_q) + 4'(col_q);
    num      = (col_q == 2'd3) ? tr_q[row_q] : AW'(cof_q[cidx]);
    nmag     = num[AW-1] ? AW'(-num) : AW'(num);
    dmag     = det_q[AW-1] ? AW'(-det_q) : AW'(det_q);
    nsh      = (col_q == 2'd3) ? (DW'(nmag) << FRAC_BITS) : (DW'(nmag) << (2 * FRAC_BITS));
    sing_now = (det_q == '0);
    ge       = (r_q >= d_q);
  end

  // rounding, saturation and result formatting
  always_comb begin
    rnd   = ((DW + 1)'(r_q) << 1) >= (DW + 1)'(dabs_q);
    mag   = MW'(q_q) + MW'(rnd);
    cap   = neg_q ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    magc  = (ovf_q || (mag > cap)) ? cap : mag;
    val_w = neg_q ? W'(~magc + MW'(1)) : W'(magc);
    res_o.element_index = {row_q, col_q};
    res_o.element_value = sing_q ? '0 : ELEM_W'(signed'(val_w));
    res_o.singular      = sing_q;
    res_o.last_element  = last;
  end

  // sequencer state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      bit_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      mvld_q  <= 1'b0;
    end else begin
      mvld_q <= issue;
      case (state_q)
        S_IDLE: begin
          if (mat_valid_i) begin
            state_q <= S_CALC;
            step_q  <= '0;
          end
        end
        S_CALC: begin
          step_q <= step_q + 1'b1;
          if (step_q == NOPS) begin
            state_q <= S_INIT;
            row_q   <= '0;
            col_q   <= '0;
          end
        end
        S_INIT: begin
          bit_q   <= BIT_W'(W + 1);
          state_q <= sing_now ? S_OUT : S_RUN;
        end
        S_RUN: begin
          if (bit_q == '0) begin
            state_q <= S_OUT;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_OUT: begin
          if (!res_full_i) begin
            if (last) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_INIT;
            end
            if (col_q == 2'd3) begin
              col_q <= '0;
              row_q <= row_q + 1'b1;
            end else begin
              col_q <= col_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (mat_pop_o) begin
      m_q[0]  <= ext(mat_i.r0c0);
      m_q[1]  <= ext(mat_i.r0c1);
      m_q[2]  <= ext(mat_i.r0c2);
      m_q[3]  <= ext(mat_i.r0c3);
      m_q[4]  <= ext(mat_i.r1c0);
      m_q[5]  <= ext(mat_i.r1c1);
      m_q[6]  <= ext(mat_i.r1c2);
      m_q[7]  <= ext(mat_i.r1c3);
      m_q[8]  <= ext(mat_i.r2c0);
      m_q[9]  <= ext(mat_i.r2c1);
      m_q[10] <= ext(mat_i.r2c2);
      m_q[11] <= ext(mat_i.r2c3);
    end
    if (issue) begin
      prod_q <= PW'(a_op) * PW'(b_op);
      tag_q  <= '{hi: op.hi, neg: op.neg, first: op.first, dst: op.dst, didx: op.didx};
    end
    if (mvld_q) begin
      acc_q <= acc_d;
      case (tag_q.dst)
        D_COF:   cof_q[tag_q.didx] <= acc_d[CW-1:0];
        D_DET:   det_q <= acc_d;
        D_TR:    tr_q[tag_q.didx[1:0]] <= acc_d;
        default: ;
      endcase
    end
    if (state_q == S_INIT) begin
      r_q    <= nsh;
      d_q    <= DW'(dmag) << (W + 1);
      dabs_q <= dmag;
      q_q    <= '0;
      ovf_q  <= 1'b0;
      neg_q  <= num[AW-1] ^ det_q[AW-1];
      sing_q <= sing_now;
    end
    if (state_q == S_RUN) begin
      if (bit_q == BIT_W'(W + 1)) begin
        ovf_q <= ge;
      end else begin
        if (ge) begin
          r_q <= r_q - d_q;
        end
        q_q <= {q_q[QW-2:0], ge};
      end
      d_q <= d_q >> 1;
    end
  end

endmodule

### src/affine_3x4_matrix_inverse_unit.sv
// Affine 3x4 inverse: 2-deep input queue, inverse engine, 2-deep result queue.
// Products are sequenced first, then each of the 12 elements is divided in turn by the
// shared restoring divider; a singular matrix skips the divisions. A new matrix is taken
// only after the last element of the previous one is pushed to the result queue.
// Reset: asynchronous, active low; clears queues and the sequencer, no clearing pass.
module affine_3x4_matrix_inverse_unit #(
  parameter int unsigned FRAC_BITS = aff_pkg::DEF_FRAC_BITS,
  parameter int unsigned WORD_BITS = aff_pkg::DEF_WORD_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aff_pkg::in_item_t  in_data_i,
  input  logic               push,
  output logic               full,
  output aff_pkg::out_item_t out_data_o,
  output logic               empty,
  input  logic               pop
);
  import aff_pkg::*;

  in_item_t  mat;
  logic      mat_empty, mat_pop;
  out_item_t res;
  logic      res_push, res_full;

  // front queue of matrices
  aff_fifo #(.T(in_item_t), .DEPTH(QUEUE_DEPTH)) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (in_data_i),
    .push_i  (push),
    .full_o  (full),
    .data_o  (mat),
    .pop_i   (mat_pop),
    .empty_o (mat_empty)
  );

  // inverse engine
  aff_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mat_i       (mat),
    .mat_valid_i (!mat_empty),
    .mat_pop_o   (mat_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue
  aff_fifo #(.T(out_item_t), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (res),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_o  (out_data_o),
    .pop_i   (pop),
    .empty_o (empty)
  );

endmodule
